// ===== rtl/pdm_pkg.sv =====
// Package for the PCM downmix, volume, DAC and level meter block.
// Holds payload structs, lane control types and shared constants; no dependencies.
`default_nettype none

package pdm_pkg;

   localparam int MAX_FRAMES_DEF = 1024;
   localparam int SAMPLE_W       = 16;
   localparam int SQ_W           = 31;   // a squared 16-bit sample fits in 31 bits
   localparam int VOL_W          = 9;
   localparam int DAC_W          = 8;
   localparam int LEVEL_W        = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 9;

   localparam logic [VOL_W-1:0] VOL_UNITY = 9'd256;

   localparam logic [CSR_IDX_W-1:0] CSR_VOLUME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MUTE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEREO = 2'd2;

   localparam logic MODE_FRAME = 1'b0;
   localparam logic MODE_POP   = 1'b1;

   typedef struct packed {
      logic                       mode;
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last_of_chunk;
      logic                       level_channel;
   } req_type;

   typedef struct packed {
      logic [DAC_W-1:0]   dac_code;
      logic [LEVEL_W-1:0] level;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic clear;
   } lane_ctrl_type;

   typedef struct packed {
      logic               busy;
      logic [LEVEL_W-1:0] held;
   } lane_stat_type;

endpackage

`default_nettype wire

// ===== rtl/pcm_downmix_volume_dac_meter_core.sv =====
// PCM downmix, volume, 8-bit DAC encoder and RMS level meter, top level.
// Each accepted item passes through the mix registers and the EXEC state into the output
// register, which waits while the output stalls; no new item is taken before then.
// A chunk end also holds off the next item for the per-lane divide and square root.
// Synchronous reset clears configuration to unity gain, unmuted, stereo, and clears
// sums, frame count and held levels. Depends on pdm_pkg, pdm_mix, pdm_lane.
`default_nettype none

module pcm_downmix_volume_dac_meter_core #(
   parameter int MAX_FRAMES = pdm_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire pdm_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output pdm_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pdm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [pdm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int SUM_W = pdm_pkg::SQ_W + CNT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [pdm_pkg::VOL_W-1:0] volume_ff, volume_in;
   logic mute_ff, mute_in;
   logic stereo_ff, stereo_in;
   logic [SUM_W-1:0] sum_l_ff, sum_l_in;
   logic [SUM_W-1:0] sum_r_ff, sum_r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic mode_ff, last_ff, chan_ff;
   logic rsp_valid_ff, rsp_valid_in;
   pdm_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic accept;
   logic out_free;
   logic [SUM_W-1:0] sum_l_next;
   logic [SUM_W-1:0] sum_r_next;
   logic [CNT_W-1:0] cnt_next;
   logic [pdm_pkg::SQ_W-1:0] sq_left;
   logic [pdm_pkg::SQ_W-1:0] sq_right;
   logic [pdm_pkg::DAC_W-1:0] dac_code;
   pdm_pkg::lane_ctrl_type ctrl_l, ctrl_r;
   pdm_pkg::lane_stat_type stat_l, stat_r;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   pdm_mix u_mix (
      .clock    (clock),
      .en       (accept),
      .left     (req_data.left_sample),
      .right    (req_data.right_sample),
      .stereo   (stereo_ff),
      .mute     (mute_ff),
      .volume   (volume_ff),
      .sq_left  (sq_left),
      .sq_right (sq_right),
      .dac_code (dac_code)
   );

   pdm_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_l (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl_l),
      .sum   (sum_l_next),
      .count (cnt_next),
      .stat  (stat_l)
   );

   pdm_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane_r (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl_r),
      .sum   (sum_r_next),
      .count (cnt_next),
      .stat  (stat_r)
   );

   assign sum_l_next = sum_l_ff + SUM_W'(sq_left);
   assign sum_r_next = sum_r_ff + SUM_W'(sq_right);
   assign cnt_next   = cnt_ff + CNT_W'(1);

   always_comb begin
      volume_in = volume_ff;
      mute_in   = mute_ff;
      stereo_in = stereo_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            pdm_pkg::CSR_VOLUME: volume_in = csr_wdata[pdm_pkg::VOL_W-1:0];
            pdm_pkg::CSR_MUTE:   mute_in   = csr_wdata[0];
            pdm_pkg::CSR_STEREO: stereo_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Control and result merge: frames supply the DAC code and close chunks, pops supply the level.
   always_comb begin
      state_in     = state_ff;
      sum_l_in     = sum_l_ff;
      sum_r_in     = sum_r_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ctrl_l       = '0;
      ctrl_r       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (mode_ff == pdm_pkg::MODE_POP) begin
                  rsp_data_in.dac_code = '0;
                  rsp_data_in.level    = chan_ff ? stat_r.held : stat_l.held;
                  ctrl_l.clear         = !chan_ff;
                  ctrl_r.clear         = chan_ff;
               end else begin
                  rsp_data_in.dac_code = dac_code;
                  rsp_data_in.level    = '0;
                  if (last_ff || (cnt_next >= CNT_W'(MAX_FRAMES))) begin
                     ctrl_l.start = 1'b1;
                     ctrl_r.start = 1'b1;
                     sum_l_in     = '0;
                     sum_r_in     = '0;
                     cnt_in       = '0;
                     state_in     = ST_WAIT;
                  end else begin
                     sum_l_in = sum_l_next;
                     sum_r_in = sum_r_next;
                     cnt_in   = cnt_next;
                  end
               end
            end
         end
         ST_WAIT: begin
            if (!stat_l.busy && !stat_r.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         volume_ff    <= pdm_pkg::VOL_UNITY;
         mute_ff      <= 1'b0;
         stereo_ff    <= 1'b1;
         sum_l_ff     <= '0;
         sum_r_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         volume_ff    <= volume_in;
         mute_ff      <= mute_in;
         stereo_ff    <= stereo_in;
         sum_l_ff     <= sum_l_in;
         sum_r_ff     <= sum_r_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         mode_ff <= req_data.mode;
         last_ff <= req_data.last_of_chunk;
         chan_ff <= req_data.level_channel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/pdm_mix.sv =====
// Downmix, gain and square stage: registers the squared samples and the scaled
// sample, and encodes the DAC code from the latter. Depends on pdm_pkg.
`default_nettype none

module pdm_mix (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [pdm_pkg::SAMPLE_W-1:0] left,
   input  wire logic signed [pdm_pkg::SAMPLE_W-1:0] right,
   input  wire logic                                stereo,
   input  wire logic                                mute,
   input  wire logic [pdm_pkg::VOL_W-1:0]           volume,
   output logic [pdm_pkg::SQ_W-1:0]                 sq_left,
   output logic [pdm_pkg::SQ_W-1:0]                 sq_right,
   output logic [pdm_pkg::DAC_W-1:0]                dac_code
);

   logic signed [16:0] pair_sum;
   logic signed [16:0] pair_adj;
   logic signed [15:0] mixed;
   logic signed [15:0] right_eff;
   logic [pdm_pkg::VOL_W-1:0] gain;
   logic signed [24:0] prod_in;
   logic signed [24:0] prod_ff;
   logic signed [31:0] pl;
   logic signed [31:0] pr;
   logic [pdm_pkg::SQ_W-1:0] sq_left_ff;
   logic [pdm_pkg::SQ_W-1:0] sq_right_ff;
   logic [24:0] biased;

   // Average truncates toward zero: bump negative sums up by one before the shift.
   assign pair_sum  = 17'(left) + 17'(right);
   assign pair_adj  = pair_sum + (pair_sum[16] ? 17'sd1 : 17'sd0);
   assign mixed     = stereo ? pair_adj[16:1] : left;
   assign right_eff = stereo ? right : left;

   assign gain = mute ? '0 : ((volume > pdm_pkg::VOL_UNITY) ? pdm_pkg::VOL_UNITY : volume);

   assign prod_in = 25'(mixed) * $signed({16'd0, gain});
   assign pl      = 32'(left) * 32'(left);
   assign pr      = 32'(right_eff) * 32'(right_eff);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         sq_left_ff  <= pl[pdm_pkg::SQ_W-1:0];
         sq_right_ff <= pr[pdm_pkg::SQ_W-1:0];
      end
   end

   assign biased   = prod_ff + 25'h080_0000;
   assign dac_code = biased[23:16];
   assign sq_left  = sq_left_ff;
   assign sq_right = sq_right_ff;

endmodule

`default_nettype wire

// ===== rtl/pdm_lane.sv =====
// One metering lane: bit-serial divide of the chunk sum by the frame count, then a
// two-bits-per-cycle integer square root, then the held-peak update. Depends on pdm_pkg.
`default_nettype none

module pdm_lane #(
   parameter int SUM_W = 42,
   parameter int CNT_W = 11
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pdm_pkg::lane_ctrl_type       ctrl,
   input  wire logic [SUM_W-1:0]             sum,
   input  wire logic [CNT_W-1:0]             count,
   output pdm_pkg::lane_stat_type            stat
);

   localparam int RAD_W  = SUM_W + (SUM_W % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIV  = 2'd1;
   localparam logic [1:0] PH_SQRT = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [ROOT_W:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [pdm_pkg::LEVEL_W-1:0] held_ff, held_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              div_ge;
   logic [ROOT_W+2:0] strial;
   logic [ROOT_W+2:0] stest;
   logic [ROOT_W+2:0] sdiff;
   logic              sq_ge;

   assign trial  = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge = trial >= {1'b0, div_ff};
   assign diff   = trial - {1'b0, div_ff};

   assign strial = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign stest  = {1'b0, root_ff, 2'b01};
   assign sq_ge  = strial >= stest;
   assign sdiff  = strial - stest;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      held_in  = held_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (ctrl.start) begin
               quo_in   = sum;
               rem_in   = '0;
               div_in   = count;
               step_in  = STEP_W'(SUM_W);
               phase_in = PH_DIV;
            end
            if (ctrl.clear) begin
               held_in = '0;
            end
         end
         PH_DIV: begin
            rem_in  = div_ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], div_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               // The quotient is complete; hand it to the square root as radicand.
               rad_in   = RAD_W'({quo_ff[SUM_W-2:0], div_ge});
               srem_in  = '0;
               root_in  = '0;
               step_in  = STEP_W'(ROOT_W);
               phase_in = PH_SQRT;
            end
         end
         PH_SQRT: begin
            srem_in = sq_ge ? sdiff[ROOT_W:0] : strial[ROOT_W:0];
            root_in = {root_ff[ROOT_W-2:0], sq_ge};
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
            if (root_ff > ROOT_W'(held_ff)) begin
               held_in = root_ff[pdm_pkg::LEVEL_W-1:0];
            end
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         held_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
   end

   assign stat.busy = phase_ff != PH_IDLE;
   assign stat.held = held_ff;

endmodule

`default_nettype wire

// ===== tb/pcm_downmix_volume_dac_meter_core_tb.sv =====
// Testbench for pcm_downmix_volume_dac_meter_core: DAC codes and popped RMS levels
// are checked against an in-bench model of downmix, gain, metering and chunk close.
// Depends on pdm_pkg and the core RTL.
`timescale 1ns / 1ps

module pcm_downmix_volume_dac_meter_core_tb;

   localparam int FRAME_LIMIT   = pdm_pkg::MAX_FRAMES_DEF;
   localparam int CHUNK_LATENCY = 70;
   localparam int LONG_HOLD     = 400;
   localparam int IDLE_LIMIT    = 3000;
   localparam logic [pdm_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   pdm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   pdm_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [pdm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pdm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Model state: chunk sums, frame count, held levels and register copies.
   logic [63:0]               sum_sq_left_acc;
   logic [63:0]               sum_sq_right_acc;
   int unsigned               chunk_frames;
   logic [15:0]               peak_left;
   logic [15:0]               peak_right;
   logic [pdm_pkg::VOL_W-1:0] gain_setting;
   logic                      muted;
   logic                      stereo_mix;

   pdm_pkg::rsp_type expected_responses[$];
   pdm_pkg::rsp_type oldest_response;
   int      mismatch_count = 0;
   int      burst_left = 0;
   int      idle_cycles = 0;
   int      hold_left = 0;
   logic    hold_request = 1'b0;
   int      pattern_timer = 0;
   stall_style_type stall_style = STALL_NONE;

   pcm_downmix_volume_dac_meter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] floor_sqrt(input logic [63:0] value);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem  = value;
      root = '0;
      bitv = 64'd1 << 62;
      while (bitv > rem)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root[31:0];
   endfunction

   function automatic void reset_meter_model();
      sum_sq_left_acc  = '0;
      sum_sq_right_acc = '0;
      chunk_frames     = 0;
      peak_left        = '0;
      peak_right       = '0;
      gain_setting     = pdm_pkg::VOL_UNITY;
      muted            = 1'b0;
      stereo_mix       = 1'b1;
   endfunction

   // Works out the result of one accepted item and advances the model state.
   function automatic pdm_pkg::rsp_type predict_response(input pdm_pkg::req_type item);
      pdm_pkg::rsp_type result;
      int          left_val;
      int          right_val;
      int          mixed;
      int          gain;
      logic [31:0] biased;
      logic [31:0] left_rms;
      logic [31:0] right_rms;
      result = '0;
      if (item.mode == pdm_pkg::MODE_POP) begin
         if (item.level_channel == 1'b0) begin
            result.level = peak_left;
            peak_left    = '0;
         end else begin
            result.level = peak_right;
            peak_right   = '0;
         end
         return result;
      end
      left_val  = $signed(item.left_sample);
      right_val = stereo_mix ? $signed(item.right_sample) : left_val;
      // In mono the left sample feeds both meters.
      sum_sq_left_acc  = sum_sq_left_acc + 64'(left_val * left_val);
      sum_sq_right_acc = sum_sq_right_acc + 64'(right_val * right_val);
      chunk_frames++;
      mixed = stereo_mix ? (left_val + right_val) / 2 : left_val;
      gain  = muted ? 0 : ((gain_setting > pdm_pkg::VOL_UNITY) ? 256 : int'(gain_setting));
      biased = 32'(mixed * gain + 8388608);
      result.dac_code = biased[23:16];
      if (item.last_of_chunk || chunk_frames >= FRAME_LIMIT) begin
         left_rms  = floor_sqrt(sum_sq_left_acc / 64'(chunk_frames));
         right_rms = floor_sqrt(sum_sq_right_acc / 64'(chunk_frames));
         if (left_rms > 32'(peak_left))
            peak_left = left_rms[15:0];
         if (right_rms > 32'(peak_right))
            peak_right = right_rms[15:0];
         sum_sq_left_acc  = '0;
         sum_sq_right_acc = '0;
         chunk_frames     = 0;
      end
      return result;
   endfunction

   function automatic logic [15:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 63)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pdm_pkg::req_type random_request(input int pop_odds);
      pdm_pkg::req_type item;
      item.mode          = ($urandom_range(0, 99) < pop_odds) ? pdm_pkg::MODE_POP
                                                              : pdm_pkg::MODE_FRAME;
      item.left_sample   = random_sample();
      item.right_sample  = random_sample();
      item.last_of_chunk = ($urandom_range(0, 5) == 0);
      item.level_channel = 1'($urandom_range(0, 1));
      return item;
   endfunction

   function automatic pdm_pkg::req_type make_frame(input int left_val,
                                                   input int right_val,
                                                   input logic last);
      pdm_pkg::req_type item;
      item               = '0;
      item.mode          = pdm_pkg::MODE_FRAME;
      item.left_sample   = 16'(left_val);
      item.right_sample  = 16'(right_val);
      item.last_of_chunk = last;
      return item;
   endfunction

   function automatic pdm_pkg::req_type make_pop(input logic channel);
      pdm_pkg::req_type item;
      item               = '0;
      item.mode          = pdm_pkg::MODE_POP;
      item.level_channel = channel;
      return item;
   endfunction

   // The sender offers items in bursts; a gap may open before each burst.
   task automatic send_item(input pdm_pkg::req_type item);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_responses.push_back(predict_response(item));
   endtask

   task automatic pause_sender();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic wait_for_responses();
      while (expected_responses.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [pdm_pkg::CSR_IDX_W-1:0] index,
                                 input logic [pdm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         pdm_pkg::CSR_VOLUME: gain_setting = data;
         pdm_pkg::CSR_MUTE:   muted = data[0];
         pdm_pkg::CSR_STEREO: stereo_mix = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Registers change only once the block has gone quiet.
   task automatic apply_settings(input logic [pdm_pkg::VOL_W-1:0] volume,
                                 input logic mute_on, input logic stereo_on);
      pause_sender();
      wait_for_responses();
      repeat (CHUNK_LATENCY) @(posedge clock);
      write_register(pdm_pkg::CSR_VOLUME, volume);
      write_register(pdm_pkg::CSR_MUTE, {8'($urandom), mute_on});
      write_register(pdm_pkg::CSR_STEREO, {8'($urandom), stereo_on});
   endtask

   task automatic test_stereo_extremes();
      send_item(make_frame(32767, 32767, 1'b0));
      send_item(make_frame(-32768, -32768, 1'b0));
      send_item(make_frame(32767, -32768, 1'b0));
      // Averages of odd negative sums must truncate toward zero.
      send_item(make_frame(-1, 0, 1'b0));
      send_item(make_frame(-3, 0, 1'b0));
      send_item(make_frame(1, -2, 1'b0));
      send_item(make_frame(0, 0, 1'b1));
      send_item(make_pop(1'b0));
      send_item(make_pop(1'b1));
      send_item(make_pop(1'b0));
   endtask

   task automatic test_volume_range();
      logic [pdm_pkg::VOL_W-1:0] volumes[6];
      volumes = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd257, 9'd511};
      foreach (volumes[i]) begin
         apply_settings(volumes[i], 1'b0, 1'b1);
         send_item(make_frame((i % 2) ? -32768 : 32767, (i % 2) ? -32768 : 32767,
                              i == 5));
      end
      apply_settings(pdm_pkg::VOL_UNITY, 1'b0, 1'b1);
   endtask

   task automatic test_mute();
      apply_settings(9'd300, 1'b1, 1'b1);
      send_item(make_frame(32767, 32767, 1'b0));
      send_item(make_frame(-32768, -32768, 1'b1));
      apply_settings(pdm_pkg::VOL_UNITY, 1'b0, 1'b1);
   endtask

   task automatic test_mono_metering();
      apply_settings(pdm_pkg::VOL_UNITY, 1'b0, 1'b0);
      send_item(make_frame(-32768, 5, 1'b0));
      send_item(make_frame(100, -32768, 1'b1));
      send_item(make_pop(1'b1));
      send_item(make_pop(1'b0));
      apply_settings(pdm_pkg::VOL_UNITY, 1'b0, 1'b1);
   endtask

   task automatic test_unused_register();
      pause_sender();
      wait_for_responses();
      repeat (CHUNK_LATENCY) @(posedge clock);
      write_register(CSR_UNUSED, 9'h1FF);
      send_item(make_frame(20000, -20000, 1'b1));
      send_item(make_pop(1'b1));
   endtask

   // A chunk with no end flag has to close by itself at the frame limit.
   task automatic test_forced_chunk_end();
      pdm_pkg::req_type item;
      apply_settings(pdm_pkg::VOL_UNITY, 1'b0, 1'b1);
      for (int n = 0; n < FRAME_LIMIT + 6; n++) begin
         item = random_request(0);
         item.last_of_chunk = 1'b0;
         send_item(item);
      end
      send_item(make_pop(1'b0));
      send_item(make_pop(1'b1));
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: apply_settings(9'd511, 1'b0, 1'b1);
            1: apply_settings(9'd0, 1'b0, 1'b0);
            default: apply_settings(9'($urandom_range(0, 511)),
                                    $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
         endcase
         for (int n = 0; n < 80; n++) begin
            // The receiver holds off while items keep coming, so the block backs up.
            if (phase == 1 && n == 10)
               hold_request = 1'b1;
            if (phase == 3 && n == 50) begin
               pause_sender();
               wait_for_responses();
            end
            send_item(random_request(12));
         end
      end
   endtask

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = LONG_HOLD;
         hold_request = 1'b0;
      end
      pattern_timer++;
      if (pattern_timer % 97 == 0)
         stall_style = stall_style_type'($urandom_range(0, 3));
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 1) == 0);
            STALL_PERIODIC: rsp_stall <= ((pattern_timer % 5) < 2);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("result with none expected: dac_code %0d level %0d",
                   rsp_data.dac_code, rsp_data.level);
            mismatch_count++;
         end else begin
            oldest_response = expected_responses.pop_front();
            if (rsp_data.dac_code !== oldest_response.dac_code) begin
               $error("dac_code expected %0d actual %0d",
                      oldest_response.dac_code, rsp_data.dac_code);
               mismatch_count++;
            end
            if (rsp_data.level !== oldest_response.level) begin
               $error("level expected %0d actual %0d",
                      oldest_response.level, rsp_data.level);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset_meter_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_stereo_extremes();
      test_volume_range();
      test_mute();
      test_mono_metering();
      test_unused_register();
      test_forced_chunk_end();
      test_random_traffic();

      pause_sender();
      wait_for_responses();
      repeat (CHUNK_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
